>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> rtl/nmai_pkg.sv
`timescale 1ns / 1ps
package nmai_pkg;

  localparam int DIM       = 2;
  localparam int MAX_MODES = 64;

  localparam int COORD_W = 16;
  localparam int MAG_W   = COORD_W + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ACC_W   = SQ_W + $clog2(DIM);
  localparam int LIM_W   = 2 * COORD_W;
  localparam int IDX_W   = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int CNT_W   = $clog2(MAX_MODES + 1);
  localparam int EXT_W   = IDX_W + 1;
  localparam int D_W     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int OIDX_W  = 6;

  typedef logic [DIM-1:0][COORD_W-1:0] coord_vec_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_0;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_3;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] mode_0;
    logic signed [COORD_W-1:0] mode_1;
    logic signed [COORD_W-1:0] mode_2;
    logic signed [COORD_W-1:0] mode_3;
    logic [OIDX_W-1:0]         cluster_index;
    logic                      new_cluster;
    logic                      table_full;
  } result_t;

  // Used coordinates of a point; the rest are dropped.
  function automatic coord_vec_t point_to_vec(point_t p);
    logic [3:0][COORD_W-1:0] w;
    coord_vec_t v;
    w[0] = p.coord_0;
    w[1] = p.coord_1;
    w[2] = p.coord_2;
    w[3] = p.coord_3;
    for (int d = 0; d < DIM; d++) begin
      v[d] = w[d];
    end
    return v;
  endfunction

  function automatic result_t make_result(coord_vec_t v, logic [OIDX_W-1:0] idx,
                                          logic is_new, logic is_full);
    logic [3:0][COORD_W-1:0] w;
    result_t r;
    w = '0;
    for (int d = 0; d < DIM; d++) begin
      w[d] = v[d];
    end
    r.mode_0        = w[0];
    r.mode_1        = w[1];
    r.mode_2        = w[2];
    r.mode_3        = w[3];
    r.cluster_index = idx;
    r.new_cluster   = is_new;
    r.table_full    = is_full;
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                logic [COORD_W-1:0] b);
    logic signed [MAG_W-1:0] diff;
    diff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  endfunction

endpackage

>>> rtl/nearest_mode_assign_or_insert_top.sv
`timescale 1ns / 1ps
// Channel  | Handshake           | Payload
// ---------+---------------------+----------------------
// point in | start, busy         | point (point_t)
// result   | done (one cycle)    | result (result_t)
// config   | cfg_we              | cfg_wdata (match_radius)
//
// A transfer first squares the radius (S_RAD, S_LIM), then scans the stored modes
// in turn (memory read, one pass of the single squarer per coordinate, compare),
// and inserts the point when nothing matches and the table has room. done pulses
// the cycle after the last step; busy is low again then.
// rst is synchronous: mode count 0, match_radius 256; the table needs no clearing.
// The receiver cannot stall; each result is flagged by done for one cycle only.
`include "assert_macros.svh"
module nearest_mode_assign_or_insert_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  nmai_pkg::point_t       point,
  output logic                   done,
  output nmai_pkg::result_t      result,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RAD  = 8'b0000_0010,
    S_LIM  = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_ACC  = 8'b0010_0000,
    S_CMP  = 8'b0100_0000,
    S_NEW  = 8'b1000_0000
  } state_t;

  state_t                          state, state_next;
  logic [15:0]                     match_radius;
  logic [nmai_pkg::CNT_W-1:0]      mode_count;
  logic [nmai_pkg::IDX_W-1:0]      mode_idx;
  logic [nmai_pkg::D_W-1:0]        coord_idx;
  nmai_pkg::coord_vec_t            pt;
  logic [nmai_pkg::LIM_W-1:0]      lim;
  nmai_pkg::coord_vec_t            rd_data;
  logic [nmai_pkg::MAG_W-1:0]      sq_x;
  logic [nmai_pkg::SQ_W-1:0]       sq;
  logic [nmai_pkg::ACC_W-1:0]      acc;
  logic                            hit, last_mode, last_coord, has_room;
  logic [nmai_pkg::IDX_W+5:0]      idx_ext;
  logic [nmai_pkg::CNT_W+5:0]      cnt_ext;

  assign busy       = (state != S_IDLE);
  assign hit        = (acc <= nmai_pkg::ACC_W'(lim));
  assign last_mode  = (({1'b0, mode_idx} + nmai_pkg::EXT_W'(1)) ==
                       nmai_pkg::EXT_W'(mode_count));
  assign last_coord = (coord_idx == nmai_pkg::D_W'(nmai_pkg::DIM - 1));
  assign has_room   = (mode_count != nmai_pkg::CNT_W'(nmai_pkg::MAX_MODES));
  assign idx_ext    = {6'b0, mode_idx};
  assign cnt_ext    = {6'b0, mode_count};

  always_comb begin
    if (state == S_RAD) begin
      sq_x = {1'b0, match_radius};
    end else begin
      sq_x = nmai_pkg::abs_diff(pt[coord_idx], rd_data[coord_idx]);
    end
  end

  nmai_sqacc u_sqacc (
    .clk     (clk),
    .x       (sq_x),
    .acc_en  (state == S_ACC),
    .acc_clr (coord_idx == '0),
    .sq      (sq),
    .acc     (acc)
  );

  nmai_store u_store (
    .clk   (clk),
    .we    ((state == S_NEW) && has_room),
    .waddr (mode_count[nmai_pkg::IDX_W-1:0]),
    .wdata (pt),
    .re    (state == S_RD),
    .raddr (mode_idx),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_RAD;
      S_RAD:  state_next = S_LIM;
      S_LIM:  state_next = (mode_count == '0) ? S_NEW : S_RD;
      S_RD:   state_next = S_MUL;
      S_MUL:  state_next = S_ACC;
      S_ACC:  state_next = last_coord ? S_CMP : S_MUL;
      S_CMP: begin
        priority if (hit) state_next = S_IDLE;
        else if (last_mode) state_next = S_NEW;
        else state_next = S_RD;
      end
      S_NEW:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      match_radius <= 16'd256;
      mode_count   <= '0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == S_CMP) && hit) || (state == S_NEW);
      if (cfg_we) begin
        match_radius <= cfg_wdata;
      end
      if ((state == S_NEW) && has_room) begin
        mode_count <= mode_count + nmai_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        pt        <= nmai_pkg::point_to_vec(point);
        mode_idx  <= '0;
        coord_idx <= '0;
      end
      S_LIM: lim <= sq[nmai_pkg::LIM_W-1:0];
      S_ACC: coord_idx <= last_coord ? '0 : coord_idx + nmai_pkg::D_W'(1);
      S_CMP: begin
        if (hit) begin
          result <= nmai_pkg::make_result(rd_data, idx_ext[5:0], 1'b0, 1'b0);
        end else if (!last_mode) begin
          mode_idx <= mode_idx + nmai_pkg::IDX_W'(1);
        end
      end
      S_NEW: begin
        if (has_room) begin
          result <= nmai_pkg::make_result(pt, cnt_ext[5:0], 1'b1, 1'b0);
        end else begin
          result <= nmai_pkg::make_result(pt, '0, 1'b0, 1'b1);
        end
      end
      default: ;
    endcase
  end

  `ASSERT_CLK(a_done_src, clk, rst, done |-> ($past(state) == S_CMP || $past(state) == S_NEW))
  `ASSERT_NEVER(a_count_max, clk, rst, mode_count > nmai_pkg::CNT_W'(nmai_pkg::MAX_MODES))
  `ASSERT_NEVER(a_flags_excl, clk, rst, done && result.new_cluster && result.table_full)
  `ASSERT_CLK(a_count_step, clk, rst, (!$past(rst) && mode_count != $past(mode_count)) |-> (done && result.new_cluster))

endmodule

>>> rtl/nmai_sqacc.sv
`timescale 1ns / 1ps
module nmai_sqacc (
  input  logic                       clk,
  input  logic [nmai_pkg::MAG_W-1:0] x,
  input  logic                       acc_en,
  input  logic                       acc_clr,
  output logic [nmai_pkg::SQ_W-1:0]  sq,
  output logic [nmai_pkg::ACC_W-1:0] acc
);

  always_ff @(posedge clk) begin
    sq <= x * x;
    if (acc_en) begin
      acc <= (acc_clr ? '0 : acc) + nmai_pkg::ACC_W'(sq);
    end
  end

endmodule

>>> rtl/nmai_store.sv
`timescale 1ns / 1ps
module nmai_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [nmai_pkg::IDX_W-1:0] waddr,
  input  nmai_pkg::coord_vec_t       wdata,
  input  logic                       re,
  input  logic [nmai_pkg::IDX_W-1:0] raddr,
  output nmai_pkg::coord_vec_t       rdata
);

  nmai_pkg::coord_vec_t mem [nmai_pkg::MAX_MODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
